>>> sv/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types and constants for the base64 stream encoder
// Holds the group record passed from front to back and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [6:0] PAD_CHAR    = 7'h3D;
  localparam logic [5:0] SEXTET_MASK = 6'h3F;

  // Number of message bytes present in a group
  localparam logic [1:0] TOTAL_ONE   = 2'd1;
  localparam logic [1:0] TOTAL_TWO   = 2'd2;
  localparam logic [1:0] TOTAL_THREE = 2'd3;

  // One complete or partial group, left-aligned in 24 bits
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  total;
    logic        last;
  } b64_group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

>>> sv/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front: byte collector
// Accepts bytes, holds up to two pending ones and pushes finished groups.
// ----------------------------------------------------------------------------
module b64_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tlast,   // last_byte
  output logic               push,
  output b64_pkg::b64_group_t push_data,
  input  logic               q_full
);
  import b64_pkg::*;

  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [1:0]  held;
  logic [1:0]  total;
  logic        accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held = (count_r > 2'd2) ? 2'd2 : count_r;
    total = held + 2'd1;
    pending_nxt = pending_r;
    count_nxt = count_r;
    push = 1'b0;
    push_data.last = in_tlast;
    push_data.total = total;
    case (total)
      TOTAL_THREE: push_data.group = {pending_r, in_tdata};
      TOTAL_TWO:   push_data.group = {pending_r[7:0], in_tdata, 8'h00};
      default:     push_data.group = {in_tdata, 16'h0000};
    endcase
    if (accept) begin
      if (total != TOTAL_THREE && !in_tlast) begin
        pending_nxt = {pending_r[7:0], in_tdata};
        count_nxt = total;
      end else begin
        push = 1'b1;
        pending_nxt = '0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      count_r <= '0;
    end else begin
      pending_r <= pending_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue: short group queue
// Decouples the byte collector from the character emitter.
// ----------------------------------------------------------------------------
module b64_queue #(
  parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64_pkg::b64_group_t push_data,
  input  logic                pop,
  output b64_pkg::b64_group_t pop_data,
  output logic                empty,
  output logic                full
);
  import b64_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64_group_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back: character emitter
// Takes one group from the queue and sends four characters, one per beat.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  b64_pkg::b64_group_t q_data,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [6:0] out_char, [7] zero
  output logic                out_tlast   // out_last
);
  import b64_pkg::*;

  b64_group_t  entry_r, entry_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;
  logic        load;
  logic        done;
  logic [6:0]  ch;

  // Output slot is free when empty or being taken this cycle
  assign load = active_r && (!out_valid_r || out_tready);
  assign done = load && (idx_r == 2'd3);
  assign pop  = (!active_r || done) && !q_empty;

  always_comb begin
    case (idx_r)
      2'd0: ch = sextet_char(entry_r.group[23:18] & SEXTET_MASK);
      2'd1: ch = sextet_char(entry_r.group[17:12] & SEXTET_MASK);
      2'd2: ch = (entry_r.total != TOTAL_ONE) ?
                 sextet_char(entry_r.group[11:6] & SEXTET_MASK) : PAD_CHAR;
      default: ch = (entry_r.total == TOTAL_THREE) ?
                    sextet_char(entry_r.group[5:0] & SEXTET_MASK) : PAD_CHAR;
    endcase
  end

  always_comb begin
    entry_nxt = entry_r;
    active_nxt = active_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt = ch;
      out_last_nxt = entry_r.last && (idx_r == 2'd3);
      idx_nxt = idx_r + 2'd1;
      if (done) begin
        active_nxt = 1'b0;
      end
    end
    // Refill from the queue when idle or as the previous group finishes
    if (pop) begin
      entry_nxt = q_data;
      active_nxt = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    entry_r <= entry_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

>>> sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder with '=' padding
// With the emitter idle, a group goes from a queue slot to the emitter's group
// register, and its first character is then held in the emitter output register.
// Throughput: one character per cycle while out_tready is high, set by the single
// emitter output register; each group gives four characters.
// Input is taken every cycle while the group queue has room.
// Reset (rst_n low, synchronous) clears pending bytes, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // out_last
);
  import b64_pkg::*;

  b64_group_t push_data;
  b64_group_t pop_data;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
